// File: rtl/euq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// euq_pkg
// Widths, fixed-point constants and the CORDIC arctangent table shared by
// the Euler angle to quaternion converter.
// ----------------------------------------------------------------------------
package euq_pkg;

  localparam int ANGLE_BITS   = 16;
  localparam int QUAT_BITS    = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int FRAC_A       = ANGLE_BITS - 4;
  localparam int FRAC_Q       = QUAT_BITS - 2;

  // CORDIC angle, datapath and sine/cosine widths (30 and 20 fraction bits)
  localparam int ZW  = 34;
  localparam int XW  = 33;
  localparam int SCW = 23;
  localparam int ZSH = 29 - FRAC_A;

  // Triple product and quaternion component widths
  localparam int TW = 64;
  localparam int QW = 33;

  // Norm and divider widths
  localparam int NRMW = 32;
  localparam int QB   = FRAC_Q + 2;
  localparam int NW   = NRMW + FRAC_Q;

  localparam logic signed [ZW-1:0] PI_Q30     = 34'sd3373259426;
  localparam logic signed [ZW-1:0] HALFPI_Q30 = 34'sd1686629713;
  localparam logic signed [ZW-1:0] ATAN1_Q30  = 34'sd843314857;
  localparam logic signed [XW-1:0] GAIN_Q30   = 33'sd652032874;

  typedef logic signed [ANGLE_BITS-1:0] angle_t;
  typedef logic signed [QUAT_BITS-1:0]  quat_t;
  typedef logic signed [SCW-1:0]        sc_t;
  typedef logic signed [QW-1:0]         qc_t;
  typedef logic        [NRMW-1:0]       nrm_t;

  typedef struct packed {
    sc_t cos_v;
    sc_t sin_v;
  } sincos_t;

  typedef logic signed [ZW-1:0] atan_tab_t [CORDIC_STEPS];

  // atan(2^-i) by its series, 60 fraction bits, rounded to 30
  function automatic atan_tab_t atan_table();
    atan_tab_t         tab;
    longint unsigned   acc;
    longint unsigned   term;
    int                i;
    int                n;
    bit                neg;
    for (i = 0; i < CORDIC_STEPS; i++) begin
      if (i == 0) begin
        tab[i] = ATAN1_Q30;
      end else begin
        acc = 64'd0;
        neg = 1'b0;
        for (n = 1; i * n <= 60; n += 2) begin
          term = (64'd1 << (60 - i * n)) / 64'(n);
          acc  = neg ? acc - term : acc + term;
          neg  = !neg;
        end
        tab[i] = ZW'((acc + (64'd1 << 29)) >> 30);
      end
    end
    return tab;
  endfunction

  localparam atan_tab_t ATAN_TAB = atan_table();

endpackage
`default_nettype wire

// File: rtl/euq_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// euq_if
// Valid/ready channels of the converter: attitude words in, quaternion
// words out.
// ----------------------------------------------------------------------------
interface euq_in_if;
  logic            valid;
  logic            ready;
  euq_pkg::angle_t roll_angle;
  euq_pkg::angle_t pitch_angle;
  euq_pkg::angle_t yaw_angle;
  modport source (output valid, output roll_angle, output pitch_angle,
                  output yaw_angle, input ready);
  modport sink   (input valid, input roll_angle, input pitch_angle,
                  input yaw_angle, output ready);
endinterface

interface euq_out_if;
  logic           valid;
  logic           ready;
  euq_pkg::quat_t quat_w;
  euq_pkg::quat_t quat_x;
  euq_pkg::quat_t quat_y;
  euq_pkg::quat_t quat_z;
  modport source (output valid, output quat_w, output quat_x, output quat_y,
                  output quat_z, input ready);
  modport sink   (input valid, input quat_w, input quat_x, input quat_y,
                  input quat_z, output ready);
endinterface
`default_nettype wire

// File: rtl/euq_cordic.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// euq_cordic
// One angle lane: halve, fold into [-pi/2, pi/2], run a pipelined
// rotation-mode CORDIC and round sine and cosine to 20 fraction bits.
// ----------------------------------------------------------------------------
module euq_cordic (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    en,
  input  wire                    in_valid,
  input  wire euq_pkg::angle_t   angle,
  output logic                   out_valid,
  output euq_pkg::sincos_t       sc
);
  localparam int N = euq_pkg::CORDIC_STEPS;
  localparam int XW = euq_pkg::XW;
  localparam int ZW = euq_pkg::ZW;

  logic signed [XW-1:0] x_r [0:N];
  logic signed [XW-1:0] y_r [0:N];
  logic signed [ZW-1:0] z_r [0:N];
  logic                 f_r [0:N];
  logic                 v_r [0:N];

  logic signed [ZW-1:0] z0;
  logic signed [ZW-1:0] zf;
  logic                 flip;

  // Halve the angle and fold it
  always_comb begin
    z0   = ZW'(angle) <<< euq_pkg::ZSH;
    zf   = z0;
    flip = 1'b0;
    if (z0 > euq_pkg::HALFPI_Q30) begin
      zf   = z0 - euq_pkg::PI_Q30;
      flip = 1'b1;
    end else if (z0 < -euq_pkg::HALFPI_Q30) begin
      zf   = z0 + euq_pkg::PI_Q30;
      flip = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= euq_pkg::GAIN_Q30;
      y_r[0] <= '0;
      z_r[0] <= zf;
      f_r[0] <= flip;
    end
  end

  // Micro-rotations, one per stage
  for (genvar i = 0; i < N; i++) begin : g_step
    localparam logic signed [ZW-1:0] ATAN_I = euq_pkg::ATAN_TAB[i];
    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;
    assign dx = y_r[i] >>> i;
    assign dy = x_r[i] >>> i;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else if (en) begin
        v_r[i+1] <= v_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        f_r[i+1] <= f_r[i];
        if (!z_r[i][ZW-1]) begin
          x_r[i+1] <= x_r[i] - dx;
          y_r[i+1] <= y_r[i] + dy;
          z_r[i+1] <= z_r[i] - ATAN_I;
        end else begin
          x_r[i+1] <= x_r[i] + dx;
          y_r[i+1] <= y_r[i] - dy;
          z_r[i+1] <= z_r[i] + ATAN_I;
        end
      end
    end
  end

  // Undo the fold and round to 20 fraction bits
  logic signed [XW-1:0] xf, yf, xr, yr;
  always_comb begin
    xf = f_r[N] ? -x_r[N] : x_r[N];
    yf = f_r[N] ? -y_r[N] : y_r[N];
    xr = (xf + XW'(512)) >>> 10;
    yr = (yf + XW'(512)) >>> 10;
  end

  logic             v_out_r;
  euq_pkg::sincos_t sc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_out_r <= 1'b0;
    end else if (en) begin
      v_out_r <= v_r[N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sc_r.cos_v <= xr[euq_pkg::SCW-1:0];
      sc_r.sin_v <= yr[euq_pkg::SCW-1:0];
    end
  end

  assign out_valid = v_out_r;
  assign sc        = sc_r;

endmodule
`default_nettype wire

// File: rtl/euq_quat.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// euq_quat
// Merge the three lanes: pair products, split triple products, then the
// two-term sums rounded to 30 fraction bits.
// ----------------------------------------------------------------------------
module euq_quat (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    en,
  input  wire                    in_valid,
  input  wire euq_pkg::sincos_t  sc_roll,
  input  wire euq_pkg::sincos_t  sc_pitch,
  input  wire euq_pkg::sincos_t  sc_yaw,
  output logic                   out_valid,
  output euq_pkg::qc_t           q [4]
);
  localparam int SCW = euq_pkg::SCW;
  localparam int PW  = 2 * SCW;
  localparam int TW  = euq_pkg::TW;
  localparam int QW  = euq_pkg::QW;

  logic [3:0] v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[2:0], in_valid};
    end
  end

  // Pair products of roll and pitch: cc, ss, sc, cs
  logic signed [PW-1:0] pr_r [4];
  euq_pkg::sc_t         c3_r, s3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      pr_r[0] <= sc_roll.cos_v * sc_pitch.cos_v;
      pr_r[1] <= sc_roll.sin_v * sc_pitch.sin_v;
      pr_r[2] <= sc_roll.sin_v * sc_pitch.cos_v;
      pr_r[3] <= sc_roll.cos_v * sc_pitch.sin_v;
      c3_r    <= sc_yaw.cos_v;
      s3_r    <= sc_yaw.sin_v;
    end
  end

  // Triple products as high and low partial products
  logic signed [PW-1:0]   pa [8];
  euq_pkg::sc_t           tb [8];
  logic signed [PW-1:0]   hi_r [8];
  logic signed [PW:0]     lo_r [8];

  always_comb begin
    pa[0] = pr_r[0]; tb[0] = c3_r;
    pa[1] = pr_r[1]; tb[1] = s3_r;
    pa[2] = pr_r[2]; tb[2] = c3_r;
    pa[3] = pr_r[3]; tb[3] = s3_r;
    pa[4] = pr_r[3]; tb[4] = c3_r;
    pa[5] = pr_r[2]; tb[5] = s3_r;
    pa[6] = pr_r[0]; tb[6] = s3_r;
    pa[7] = pr_r[1]; tb[7] = c3_r;
  end

  for (genvar k = 0; k < 8; k++) begin : g_tri
    always_ff @(posedge clk) begin
      if (en) begin
        hi_r[k] <= $signed(pa[k][PW-1:SCW]) * tb[k];
        lo_r[k] <= $signed({1'b0, pa[k][SCW-1:0]}) * tb[k];
      end
    end
  end

  // Recombine the partial products
  logic signed [TW-1:0] t_r [8];

  for (genvar k = 0; k < 8; k++) begin : g_join
    always_ff @(posedge clk) begin
      if (en) begin
        t_r[k] <= (TW'(hi_r[k]) <<< SCW) + TW'(lo_r[k]);
      end
    end
  end

  // Sum the term pairs and round to 30 fraction bits
  localparam logic signed [TW-1:0] HALF30 = 64'sh2000_0000;
  logic signed [TW-1:0] s [4];
  euq_pkg::qc_t         q_r [4];

  always_comb begin
    s[0] = (t_r[0] + t_r[1] + HALF30) >>> 30;
    s[1] = (t_r[2] - t_r[3] + HALF30) >>> 30;
    s[2] = (t_r[4] + t_r[5] + HALF30) >>> 30;
    s[3] = (t_r[6] - t_r[7] + HALF30) >>> 30;
  end

  for (genvar k = 0; k < 4; k++) begin : g_sum
    always_ff @(posedge clk) begin
      if (en) begin
        q_r[k] <= s[k][QW-1:0];
      end
    end
    assign q[k] = q_r[k];
  end

  assign out_valid = v_r[3];

endmodule
`default_nettype wire

// File: rtl/euq_norm.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// euq_norm
// Quaternion norm: squares, their sum, then a pipelined digit-by-digit
// floor square root, one result bit per stage. Components ride along.
// ----------------------------------------------------------------------------
module euq_norm (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    en,
  input  wire                    in_valid,
  input  wire euq_pkg::qc_t      q_in [4],
  output logic                   out_valid,
  output euq_pkg::qc_t           q_out [4],
  output euq_pkg::nrm_t          norm
);
  localparam int QW = euq_pkg::QW;
  localparam int RS = euq_pkg::NRMW;

  // Squares of the magnitudes
  logic        [63:0] sq_r [4];
  euq_pkg::qc_t       qa_r [4];
  logic               va_r;

  for (genvar k = 0; k < 4; k++) begin : g_sq
    logic [QW-1:0] mag;
    assign mag = q_in[k][QW-1] ? QW'(-q_in[k]) : QW'(q_in[k]);
    always_ff @(posedge clk) begin
      if (en) begin
        sq_r[k] <= 64'(mag[RS-1:0]) * 64'(mag[RS-1:0]);
        qa_r[k] <= q_in[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (en) begin
      va_r <= in_valid;
    end
  end

  // Sum of squares feeds the root pipeline
  logic        [63:0] v_r [0:RS];
  logic        [63:0] r_r [0:RS];
  euq_pkg::qc_t       qp_r [0:RS][4];
  logic               vl_r [0:RS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vl_r[0] <= 1'b0;
    end else if (en) begin
      vl_r[0] <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v_r[0]  <= sq_r[0] + sq_r[1] + sq_r[2] + sq_r[3];
      r_r[0]  <= '0;
      qp_r[0] <= qa_r;
    end
  end

  // One result bit per stage
  for (genvar j = 0; j < RS; j++) begin : g_root
    localparam logic [63:0] BITJ = 64'd1 << (62 - 2 * j);
    logic [63:0] rb;
    assign rb = r_r[j] + BITJ;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vl_r[j+1] <= 1'b0;
      end else if (en) begin
        vl_r[j+1] <= vl_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        qp_r[j+1] <= qp_r[j];
        if (v_r[j] >= rb) begin
          v_r[j+1] <= v_r[j] - rb;
          r_r[j+1] <= (r_r[j] >> 1) + BITJ;
        end else begin
          v_r[j+1] <= v_r[j];
          r_r[j+1] <= r_r[j] >> 1;
        end
      end
    end
  end

  assign out_valid = vl_r[RS];
  assign q_out     = qp_r[RS];
  assign norm      = r_r[RS][RS-1:0];

endmodule
`default_nettype wire

// File: rtl/euq_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// euq_div
// One component lane: rounded restoring division of the magnitude by the
// norm, one quotient bit per stage, then sign and saturation. A zero norm
// takes the rounded component instead.
// ----------------------------------------------------------------------------
module euq_div (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    en,
  input  wire                    in_valid,
  input  wire euq_pkg::qc_t      q,
  input  wire euq_pkg::nrm_t     norm,
  output logic                   out_valid,
  output euq_pkg::quat_t         quat
);
  localparam int QW  = euq_pkg::QW;
  localparam int RS  = euq_pkg::NRMW;
  localparam int QB  = euq_pkg::QB;
  localparam int NW  = euq_pkg::NW;
  localparam int ZSW = QW - 30 + euq_pkg::FRAC_Q;
  localparam logic [QB-1:0] LIM = QB'(1) << euq_pkg::FRAC_Q;
  localparam logic signed [ZSW-1:0] LIM_S = ZSW'(LIM);

  // Numerator with half the norm added
  logic [QW-1:0]  mag;
  logic [NW-1:0]  num;
  logic signed [QW-1:0] qz;

  always_comb begin
    mag = q[QW-1] ? QW'(-q) : QW'(q);
    num = (NW'(mag[RS-1:0]) << euq_pkg::FRAC_Q) + NW'(norm >> 1);
    qz  = (q + (QW'(1) <<< (29 - euq_pkg::FRAC_Q))) >>> (30 - euq_pkg::FRAC_Q);
  end

  logic [RS-1:0]  rem_r  [0:QB];
  logic [QB-1:0]  low_r  [0:QB];
  logic [QB-1:0]  quo_r  [0:QB];
  logic [RS-1:0]  den_r  [0:QB];
  logic           neg_r  [0:QB];
  logic [ZSW-1:0] zs_r   [0:QB];
  logic           vl_r   [0:QB];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vl_r[0] <= 1'b0;
    end else if (en) begin
      vl_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= RS'(num[NW-1:QB]);
      low_r[0] <= num[QB-1:0];
      quo_r[0] <= '0;
      den_r[0] <= norm;
      neg_r[0] <= q[QW-1];
      zs_r[0]  <= qz[ZSW-1:0];
    end
  end

  // One quotient bit per stage, most significant first
  for (genvar j = 0; j < QB; j++) begin : g_quo
    logic [RS:0] t;
    logic        ge;
    assign t  = {rem_r[j], low_r[j][QB-1-j]};
    assign ge = t >= {1'b0, den_r[j]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vl_r[j+1] <= 1'b0;
      end else if (en) begin
        vl_r[j+1] <= vl_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j+1] <= ge ? RS'(t - {1'b0, den_r[j]}) : t[RS-1:0];
        quo_r[j+1] <= {quo_r[j][QB-2:0], ge};
        low_r[j+1] <= low_r[j];
        den_r[j+1] <= den_r[j];
        neg_r[j+1] <= neg_r[j];
        zs_r[j+1]  <= zs_r[j];
      end
    end
  end

  // Sign, saturate, or take the rounded component on a zero norm
  logic [QB-1:0]        d;
  logic signed [ZSW-1:0] zv;
  euq_pkg::quat_t       res;

  always_comb begin
    d  = (quo_r[QB] > LIM) ? LIM : quo_r[QB];
    zv = $signed(zs_r[QB]);
    if (den_r[QB] == '0) begin
      if (zv > LIM_S) begin
        res = QB'(LIM);
      end else if (zv < -LIM_S) begin
        res = QB'(-LIM_S);
      end else begin
        res = zv[QB-1:0];
      end
    end else begin
      res = neg_r[QB] ? $signed(-d) : $signed(d);
    end
  end

  logic           v_out_r;
  euq_pkg::quat_t quat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_out_r <= 1'b0;
    end else if (en) begin
      v_out_r <= vl_r[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quat_r <= res;
    end
  end

  assign out_valid = v_out_r;
  assign quat      = quat_r;

endmodule
`default_nettype wire

// File: rtl/euler_to_quaternion.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// euler_to_quaternion
// Roll, pitch and yaw (signed Q4.12 radians) in, unit quaternion w, x, y, z
// (signed Q2.14, saturated to plus or minus one) out, ZYX convention.
//
// in_ch carries one attitude word, out_ch one quaternion word; both are
// valid/ready, a word moving at a clock edge with valid and ready high.
// Three CORDIC lanes form the half-angle sines and cosines side by side; a
// merging stage builds the four components, then the norm is taken by a
// pipelined square root and four divider lanes normalise the components.
// Throughput: one word per cycle while out_ch is not stalled. The lanes run
// 16 CORDIC steps, 32 square-root steps and 16 quotient steps.
// The pipeline holds no state between words.
// Reset (rst_n low, synchronous) empties the pipeline.
// When the receiver stalls with a word waiting on out_ch, the whole pipeline
// holds and in_ch.ready falls until the word is taken; while out_ch has no
// waiting word, in_ch.ready stays high.
// ----------------------------------------------------------------------------
module euler_to_quaternion (
  input  wire        clk,
  input  wire        rst_n,
  euq_in_if.sink     in_ch,
  euq_out_if.source  out_ch
);
  logic adv;

  // Advance the pipeline unless the output word is held
  assign adv         = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = adv;

  logic             cv [3];
  euq_pkg::sincos_t sc [3];

  euq_cordic u_roll (
    .clk(clk), .rst_n(rst_n), .en(adv), .in_valid(in_ch.valid),
    .angle(in_ch.roll_angle), .out_valid(cv[0]), .sc(sc[0])
  );
  euq_cordic u_pitch (
    .clk(clk), .rst_n(rst_n), .en(adv), .in_valid(in_ch.valid),
    .angle(in_ch.pitch_angle), .out_valid(cv[1]), .sc(sc[1])
  );
  euq_cordic u_yaw (
    .clk(clk), .rst_n(rst_n), .en(adv), .in_valid(in_ch.valid),
    .angle(in_ch.yaw_angle), .out_valid(cv[2]), .sc(sc[2])
  );

  logic         qv;
  euq_pkg::qc_t q [4];

  euq_quat u_quat (
    .clk(clk), .rst_n(rst_n), .en(adv), .in_valid(cv[0] & cv[1] & cv[2]),
    .sc_roll(sc[0]), .sc_pitch(sc[1]), .sc_yaw(sc[2]),
    .out_valid(qv), .q(q)
  );

  logic          nv;
  euq_pkg::qc_t  qn [4];
  euq_pkg::nrm_t norm;

  euq_norm u_norm (
    .clk(clk), .rst_n(rst_n), .en(adv), .in_valid(qv), .q_in(q),
    .out_valid(nv), .q_out(qn), .norm(norm)
  );

  logic           dv [4];
  euq_pkg::quat_t res [4];

  for (genvar k = 0; k < 4; k++) begin : g_div
    euq_div u_div (
      .clk(clk), .rst_n(rst_n), .en(adv), .in_valid(nv), .q(qn[k]),
      .norm(norm), .out_valid(dv[k]), .quat(res[k])
    );
  end

  assign out_ch.valid  = dv[0] & dv[1] & dv[2] & dv[3];
  assign out_ch.quat_w = res[0];
  assign out_ch.quat_x = res[1];
  assign out_ch.quat_y = res[2];
  assign out_ch.quat_z = res[3];

endmodule
`default_nettype wire

// File: dv/euq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euq_checker
// Watches both channels of the Euler angle to quaternion converter, predicts
// each quaternion word from the accepted attitude word and compares the
// results field by field, in order.
// ----------------------------------------------------------------------------
module euq_checker (
  input  logic clk,
  input  logic rst_n,
  euq_in_if    in_ch,
  euq_out_if   out_ch,
  output int   fail_cnt,
  output int   pending_cnt
);
  import euq_pkg::*;

  typedef struct packed {
    quat_t w;
    quat_t x;
    quat_t y;
    quat_t z;
  } quat_word_t;

  localparam longint HALF_PI = 64'sd1686629713;
  localparam longint FULL_PI = 64'sd3373259426;
  localparam longint K_GAIN  = 64'sd652032874;

  longint     arctan_q30 [32];
  quat_word_t quat_due_q [$];

  // Arctangent of 2^-i, series with 60 fraction bits rounded to 30
  function automatic void fill_arctan();
    longint unsigned acc;
    longint unsigned term;
    bit              neg;
    arctan_q30[0] = 64'sd843314857;
    for (int i = 1; i < 32; i++) begin
      acc = 0;
      neg = 1'b0;
      for (int n = 1; i * n <= 60; n += 2) begin
        term = (64'd1 << (60 - i * n)) / longint'(n);
        acc  = neg ? acc - term : acc + term;
        neg  = !neg;
      end
      arctan_q30[i] = longint'((acc + (64'd1 << 29)) >> 30);
    end
  endfunction

  function automatic longint round_half_up(longint v, int s);
    if (s == 0) return v;
    return (v + (64'sd1 << (s - 1))) >>> s;
  endfunction

  // Half-angle cosine and sine by rotation CORDIC, 20 fraction bits out
  function automatic void half_sin_cos(input longint ang, output longint cv,
                                       output longint sv);
    longint xr;
    longint yr;
    longint dx;
    longint dy;
    bit     flip;
    xr   = K_GAIN;
    yr   = 0;
    flip = 1'b0;
    if (ang > HALF_PI) begin
      ang  = ang - FULL_PI;
      flip = 1'b1;
    end else if (ang < -HALF_PI) begin
      ang  = ang + FULL_PI;
      flip = 1'b1;
    end
    for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
      dx = yr >>> i;
      dy = xr >>> i;
      if (ang >= 0) begin
        xr  = xr - dx;
        yr  = yr + dy;
        ang = ang - arctan_q30[i];
      end else begin
        xr  = xr + dx;
        yr  = yr - dy;
        ang = ang + arctan_q30[i];
      end
    end
    if (flip) begin
      xr = -xr;
      yr = -yr;
    end
    cv = round_half_up(xr, 10);
    sv = round_half_up(yr, 10);
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Normalise one component, saturate to plus or minus one
  function automatic quat_t scale_comp(longint q, longint unsigned nrm);
    longint          lim;
    longint          r;
    longint unsigned mag;
    longint unsigned d;
    lim = 64'sd1 << FRAC_Q;
    if (nrm == 0) begin
      r = round_half_up(q, 30 - FRAC_Q);
    end else begin
      mag = (q < 0) ? longint'(-q) : longint'(q);
      d   = ((mag << FRAC_Q) + nrm / 2) / nrm;
      if (d > lim) d = lim;
      r = (q < 0) ? -longint'(d) : longint'(d);
    end
    if (r > lim)  r = lim;
    if (r < -lim) r = -lim;
    return quat_t'(r);
  endfunction

  function automatic quat_word_t attitude_to_quat(angle_t roll, angle_t pitch,
                                                  angle_t yaw);
    longint          cs [3];
    longint          sn [3];
    longint          qc [4];
    longint          ang [3];
    longint unsigned sq;
    longint unsigned m;
    longint unsigned nrm;
    quat_word_t      res;
    ang[0] = longint'(roll);
    ang[1] = longint'(pitch);
    ang[2] = longint'(yaw);
    for (int k = 0; k < 3; k++)
      half_sin_cos(ang[k] <<< (29 - FRAC_A), cs[k], sn[k]);
    qc[0] = round_half_up(cs[0]*cs[1]*cs[2] + sn[0]*sn[1]*sn[2], 30);
    qc[1] = round_half_up(sn[0]*cs[1]*cs[2] - cs[0]*sn[1]*sn[2], 30);
    qc[2] = round_half_up(cs[0]*sn[1]*cs[2] + sn[0]*cs[1]*sn[2], 30);
    qc[3] = round_half_up(cs[0]*cs[1]*sn[2] - sn[0]*sn[1]*cs[2], 30);
    sq = 0;
    for (int k = 0; k < 4; k++) begin
      m  = (qc[k] < 0) ? longint'(-qc[k]) : longint'(qc[k]);
      sq = sq + m * m;
    end
    nrm   = floor_sqrt(sq);
    res.w = scale_comp(qc[0], nrm);
    res.x = scale_comp(qc[1], nrm);
    res.y = scale_comp(qc[2], nrm);
    res.z = scale_comp(qc[3], nrm);
    return res;
  endfunction

  initial begin
    fail_cnt = 0;
    fill_arctan();
  end

  assign pending_cnt = quat_due_q.size();

  // Queue predictions on input words, compare on output words
  always @(posedge clk) begin
    quat_word_t due;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        quat_due_q.push_back(attitude_to_quat(in_ch.roll_angle,
                                              in_ch.pitch_angle,
                                              in_ch.yaw_angle));
      if (out_ch.valid && out_ch.ready) begin
        if (quat_due_q.size() == 0) begin
          if (fail_cnt < 10)
            $display("unexpected quaternion word w=%0d x=%0d y=%0d z=%0d",
                     out_ch.quat_w, out_ch.quat_x, out_ch.quat_y, out_ch.quat_z);
          fail_cnt <= fail_cnt + 1;
        end else begin
          due = quat_due_q.pop_front();
          if (due.w !== out_ch.quat_w || due.x !== out_ch.quat_x ||
              due.y !== out_ch.quat_y || due.z !== out_ch.quat_z) begin
            if (fail_cnt < 10)
              $display("mismatch exp w=%0d x=%0d y=%0d z=%0d got %0d %0d %0d %0d",
                       due.w, due.x, due.y, due.z, out_ch.quat_w,
                       out_ch.quat_x, out_ch.quat_y, out_ch.quat_z);
            fail_cnt <= fail_cnt + 1;
          end
        end
      end
    end
  end
endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives attitude words into the converter, directed corners first and then
// random angles, with random gaps on both sides; the checker predicts and
// compares, this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;
  import euq_pkg::*;

  localparam int N_RANDOM   = 1500;
  localparam int IDLE_LIMIT = 3000;
  localparam int PI_A       = 12868;
  localparam int HPI_A      = 6434;

  logic clk;
  logic rst_n;
  int   fail_cnt;
  int   pending_cnt;
  int   idle_cycles;
  bit   calm_out;
  int   stall_left;

  euq_in_if  in_ch ();
  euq_out_if out_ch ();

  euler_to_quaternion u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  euq_checker u_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .fail_cnt    (fail_cnt),
    .pending_cnt (pending_cnt)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Hold the word until it is taken, then idle for the gap
  task automatic send_attitude(angle_t roll, angle_t pitch, angle_t yaw, int gap);
    in_ch.valid       <= 1'b1;
    in_ch.roll_angle  <= roll;
    in_ch.pitch_angle <= pitch;
    in_ch.yaw_angle   <= yaw;
    do @(posedge clk); while (!in_ch.ready);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic angle_t pick_angle();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return angle_t'($urandom);
    if (r < 8) return angle_t'($urandom_range(0, 2 * PI_A) - PI_A);
    return angle_t'($urandom_range(0, 64) - 32);
  endfunction

  // Receiver stalls, with calm stretches
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left   <= 0;
    end else if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (!calm_out && $urandom_range(0, 9) < 3) begin
      out_ch.ready <= 1'b0;
      stall_left   <= pick_gap();
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Watchdog on cycles with no word moving
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int ext [6];
    int gap;
    bit calm_in;
    ext = '{0, 32767, -32768, PI_A, -PI_A, HPI_A};
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.roll_angle  <= '0;
    in_ch.pitch_angle <= '0;
    in_ch.yaw_angle   <= '0;
    calm_out          = 1'b0;
    calm_in           = 1'b0;
    idle_cycles       = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed corners: zero, extremes, fold points, one axis at a time
    for (int k = 0; k < 6; k++) begin
      send_attitude(angle_t'(ext[k]), 16'sd0, 16'sd0, pick_gap());
      send_attitude(16'sd0, angle_t'(ext[k]), 16'sd0, 0);
      send_attitude(16'sd0, 16'sd0, angle_t'(ext[k]), pick_gap());
    end
    send_attitude(16'sd32767, 16'sd32767, 16'sd32767, 0);
    send_attitude(-16'sd32768, -16'sd32768, -16'sd32768, 0);
    send_attitude(angle_t'(PI_A + 1), angle_t'(-PI_A - 1), angle_t'(HPI_A), 0);
    send_attitude(-16'sd1, 16'sd1, -16'sd1, 3);

    // Random part
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 250 == 0) begin
        calm_in  = ($urandom_range(0, 2) == 0);
        calm_out = ($urandom_range(0, 2) == 0);
      end
      if (n == N_RANDOM / 2) begin
        in_ch.valid <= 1'b0;
        while (pending_cnt != 0) @(posedge clk);
      end
      gap = calm_in ? 0 : pick_gap();
      send_attitude(pick_angle(), pick_angle(), pick_angle(), gap);
    end
    in_ch.valid <= 1'b0;
    calm_out = 1'b1;

    // Drain, then keep watching for anything stray before the verdict
    while (pending_cnt != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_cnt == 0 && pending_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
